>>> src/nmit_pkg.sv
// Shared widths, payload structs and cofactor index tables for the normal-matrix unit.
`timescale 1ns / 1ps
package nmit_pkg;

  localparam int ELEM_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int THR_W         = 31;
  localparam int NLANE         = 9;
  localparam int IDX_W         = 4;
  localparam int PROD_W        = 2 * ELEM_W;
  localparam int COF_W         = PROD_W + 1;
  localparam int CLO_W         = COF_W - ELEM_W;
  localparam int TERM_W        = ELEM_W + COF_W;
  localparam int DET_W         = TERM_W + 2;
  localparam int QB            = ELEM_W + 2;

  // Cofactor k is elem[0]*elem[1] - elem[2]*elem[3], elements in row-major order.
  localparam int unsigned COF_IDX [NLANE][4] = '{
    '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
    '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
    '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    logic signed [ELEM_W-1:0] a00;
    logic signed [ELEM_W-1:0] a01;
    logic signed [ELEM_W-1:0] a02;
    logic signed [ELEM_W-1:0] a10;
    logic signed [ELEM_W-1:0] a11;
    logic signed [ELEM_W-1:0] a12;
    logic signed [ELEM_W-1:0] a20;
    logic signed [ELEM_W-1:0] a21;
    logic signed [ELEM_W-1:0] a22;
  } nmit_in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] n00;
    logic signed [ELEM_W-1:0] n01;
    logic signed [ELEM_W-1:0] n02;
    logic signed [ELEM_W-1:0] n10;
    logic signed [ELEM_W-1:0] n11;
    logic signed [ELEM_W-1:0] n12;
    logic signed [ELEM_W-1:0] n20;
    logic signed [ELEM_W-1:0] n21;
    logic signed [ELEM_W-1:0] n22;
    logic                     singular;
  } nmit_out_t;

  typedef struct packed {
    logic             singular;
    logic [NLANE-1:0] neg;
  } nmit_tag_t;

endpackage

>>> src/nmit_div.sv
// Pipelined restoring divider, 9 lanes, 1 divisor; overflow stage, then a bit per stage.
`timescale 1ns / 1ps
module nmit_div
  import nmit_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           vld_i,
  input  nmit_tag_t                      tag_i,
  input  logic [DET_W-1:0]               dmag_i,
  input  logic [COF_W+2*FRAC_BITS:0]     num_i [NLANE],
  output logic                           vld_o,
  output nmit_tag_t                      tag_o,
  output logic [QB-1:0]                  quo_o [NLANE],
  output logic [NLANE-1:0]               ovf_o
);

  localparam int NUMW = COF_W + 2 * FRAC_BITS + 1;
  localparam int WW   = (NUMW > DET_W + QB) ? NUMW : DET_W + QB;

  logic             vld_r  [QB+1];
  nmit_tag_t        tag_r  [QB+1];
  logic [DET_W-1:0] dm_r   [QB+1];
  logic [WW-1:0]    rem_r  [QB+1][NLANE];
  logic [QB-1:0]    q_r    [QB+1][NLANE];
  logic [NLANE-1:0] ovf_r  [QB+1];

  for (genvar j = 0; j <= QB; j++) begin : g_st
    localparam int SH = QB - j;
    logic             vld_in;
    nmit_tag_t        tag_in;
    logic [DET_W-1:0] dm_in;
    logic [WW-1:0]    rem_in  [NLANE];
    logic [QB-1:0]    q_in    [NLANE];
    logic [NLANE-1:0] ovf_in;
    logic [WW-1:0]    dsh;
    logic [WW-1:0]    rem_nxt [NLANE];
    logic [QB-1:0]    q_nxt   [NLANE];
    logic [NLANE-1:0] ovf_nxt;

    if (j == 0) begin : g_first
      always_comb begin
        vld_in = vld_i;
        tag_in = tag_i;
        dm_in  = dmag_i;
        ovf_in = '0;
        for (int l = 0; l < NLANE; l++) begin
          rem_in[l] = WW'(num_i[l]);
          q_in[l]   = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        vld_in = vld_r[j-1];
        tag_in = tag_r[j-1];
        dm_in  = dm_r[j-1];
        ovf_in = ovf_r[j-1];
        for (int l = 0; l < NLANE; l++) begin
          rem_in[l] = rem_r[j-1][l];
          q_in[l]   = q_r[j-1][l];
        end
      end
    end

    assign dsh = WW'(dm_in) << SH;

    if (j == 0) begin : g_ovf
      // The top step only tells whether the quotient needs more than QB bits.
      always_comb begin
        ovf_nxt = ovf_in;
        for (int l = 0; l < NLANE; l++) begin
          q_nxt[l]   = q_in[l];
          rem_nxt[l] = rem_in[l];
          if (rem_in[l] >= dsh) begin
            rem_nxt[l] = rem_in[l] - dsh;
            ovf_nxt[l] = 1'b1;
          end
        end
      end
    end else begin : g_bit
      always_comb begin
        ovf_nxt = ovf_in;
        for (int l = 0; l < NLANE; l++) begin
          q_nxt[l]   = q_in[l];
          rem_nxt[l] = rem_in[l];
          if (rem_in[l] >= dsh) begin
            rem_nxt[l]    = rem_in[l] - dsh;
            q_nxt[l][SH]  = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (adv) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        tag_r[j] <= tag_in;
        dm_r[j]  <= dm_in;
        ovf_r[j] <= ovf_nxt;
        for (int l = 0; l < NLANE; l++) begin
          rem_r[j][l] <= rem_nxt[l];
          q_r[j][l]   <= q_nxt[l];
        end
      end
    end
  end

  assign vld_o = vld_r[QB];
  assign tag_o = tag_r[QB];
  assign ovf_o = ovf_r[QB];
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      quo_o[l] = q_r[QB][l];
    end
  end

endmodule

>>> src/normal_matrix_inverse_transpose.sv
// Top level of the normal-matrix unit: inverse transpose of a 3x3 fixed-point matrix.
`timescale 1ns / 1ps
// The input channel (in_valid, in_stall, in_data) carries one item: the nine
// elements of a 3x3 matrix in signed fixed point with FRAC_BITS fraction bits.
// The result channel (out_valid, out_stall, out_data) returns one item for each
// input item, in order: the cofactor matrix divided by the determinant, rounded
// to nearest with ties away from zero and saturated to 32 bits, or the
// identity with the singular flag when the determinant magnitude is at or
// below det_threshold (written over cfg_valid, cfg_ready and cfg_data).
// An item is taken in every cycle unless the pipeline is stalled. On its way it
// passes seven stages that form the cofactors, the exact determinant and their
// magnitudes, then QB + 1 = 35 stages of the nine-lane divider (an overflow
// test, then one quotient bit each) and one output register.
// When the receiver stalls a held result, the whole pipeline freezes and
// in_stall rises in the same cycle, so nothing is lost or repeated; items
// further back keep their places until the result is taken.
// A synchronous reset clears every valid bit and sets det_threshold to 1.
// Configuration is always ready and is meant to be written while idle.
module normal_matrix_inverse_transpose
  import nmit_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  nmit_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output nmit_out_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data
);

  localparam int NUMW = COF_W + 2 * FRAC_BITS + 1;
  localparam logic [ELEM_W-1:0] ONE     = ELEM_W'(1) << FRAC_BITS;
  localparam logic [QB-1:0]     MAX_POS = QB'((64'd1 << (ELEM_W - 1)) - 64'd1);
  localparam logic [QB-1:0]     MAX_NEG = QB'(64'd1 << (ELEM_W - 1));

  // Every stage moves on together unless a finished result is being held.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign cfg_ready = 1'b1;

  logic [THR_W-1:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // Stage 0: the accepted matrix, unpacked into row-major order.
  logic signed [ELEM_W-1:0] a_in [NLANE];
  always_comb begin
    a_in[0] = in_data.a00; a_in[1] = in_data.a01; a_in[2] = in_data.a02;
    a_in[3] = in_data.a10; a_in[4] = in_data.a11; a_in[5] = in_data.a12;
    a_in[6] = in_data.a20; a_in[7] = in_data.a21; a_in[8] = in_data.a22;
  end

  logic                     v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic signed [ELEM_W-1:0] a0_r [NLANE];
  // Stage 1: the two products of each cofactor.
  logic signed [PROD_W-1:0] pp1_r [NLANE];
  logic signed [PROD_W-1:0] pq1_r [NLANE];
  logic signed [ELEM_W-1:0] a1_r  [3];
  // Stage 2: exact cofactors.
  logic signed [COF_W-1:0]  cof2_r [NLANE];
  logic signed [ELEM_W-1:0] a2_r   [3];
  // Stage 3: first-row elements times the low and high halves of their cofactors.
  logic signed [ELEM_W+CLO_W:0] plo3_r [3];
  logic signed [PROD_W-1:0]     phi3_r [3];
  logic signed [COF_W-1:0]      cof3_r [NLANE];
  // Stage 4: the three determinant terms.
  logic signed [TERM_W-1:0] term4_r [3];
  logic signed [COF_W-1:0]  cof4_r  [NLANE];
  // Stage 5: the exact determinant.
  logic signed [DET_W-1:0]  det5_r;
  logic signed [COF_W-1:0]  cof5_r [NLANE];
  // Stage 6: magnitudes, signs and the singular test, ready for the divider.
  logic [DET_W-1:0] dmag6_r;
  logic [NUMW-1:0]  num6_r [NLANE];
  nmit_tag_t        tag6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  logic signed [DET_W-1:0] lim;
  logic signed [DET_W-1:0] det_abs;
  logic signed [COF_W-1:0] cof_abs [NLANE];
  nmit_tag_t               tag6_nxt;

  always_comb begin
    lim     = $signed(DET_W'(thr_r) << (2 * FRAC_BITS));
    det_abs = det5_r[DET_W-1] ? -det5_r : det5_r;
    tag6_nxt.singular = (det5_r <= lim) && (det5_r >= -lim);
    for (int k = 0; k < NLANE; k++) begin
      cof_abs[k]      = cof5_r[k][COF_W-1] ? -cof5_r[k] : cof5_r[k];
      tag6_nxt.neg[k] = cof5_r[k][COF_W-1] ^ det5_r[DET_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NLANE; k++) begin
        a0_r[k]   <= a_in[k];
        pp1_r[k]  <= a0_r[IDX_W'(COF_IDX[k][0])] * a0_r[IDX_W'(COF_IDX[k][1])];
        pq1_r[k]  <= a0_r[IDX_W'(COF_IDX[k][2])] * a0_r[IDX_W'(COF_IDX[k][3])];
        cof2_r[k] <= COF_W'(pp1_r[k]) - COF_W'(pq1_r[k]);
        cof3_r[k] <= cof2_r[k];
        cof4_r[k] <= cof3_r[k];
        cof5_r[k] <= cof4_r[k];
        num6_r[k] <= NUMW'(unsigned'(cof_abs[k])) << (2 * FRAC_BITS + 1);
      end
      for (int k = 0; k < 3; k++) begin
        a1_r[k]    <= a0_r[k];
        a2_r[k]    <= a1_r[k];
        plo3_r[k]  <= a2_r[k] * $signed({1'b0, cof2_r[k][CLO_W-1:0]});
        phi3_r[k]  <= a2_r[k] * $signed(cof2_r[k][COF_W-1:CLO_W]);
        term4_r[k] <= (TERM_W'(phi3_r[k]) <<< CLO_W) + TERM_W'(plo3_r[k]);
      end
      det5_r  <= DET_W'(term4_r[0]) + DET_W'(term4_r[1]) + DET_W'(term4_r[2]);
      dmag6_r <= unsigned'(det_abs);
      tag6_r  <= tag6_nxt;
    end
  end

  // Nine quotients |cofactor| << (2*FRAC_BITS + 1) / |det|, one extra bit for rounding.
  logic          dv_vld;
  nmit_tag_t     dv_tag;
  logic [QB-1:0] dv_quo [NLANE];
  logic [NLANE-1:0] dv_ovf;

  nmit_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vld_i  (v6_r),
    .tag_i  (tag6_r),
    .dmag_i (dmag6_r),
    .num_i  (num6_r),
    .vld_o  (dv_vld),
    .tag_o  (dv_tag),
    .quo_o  (dv_quo),
    .ovf_o  (dv_ovf)
  );

  // Rounding halves the quotient after adding one, then saturation and the
  // identity substitution for a singular matrix.
  logic signed [ELEM_W-1:0] res   [NLANE];
  logic [QB:0]              q_inc [NLANE];
  logic [QB-1:0]            q_rnd [NLANE];
  nmit_out_t                out_nxt;
  logic                     out_valid_r;
  nmit_out_t                out_r;

  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      q_inc[k] = {1'b0, dv_quo[k]} + (QB + 1)'(1);
      q_rnd[k] = q_inc[k][QB:1];
      if (dv_tag.singular) begin
        res[k] = (k % 4 == 0) ? ONE : '0;
      end else if (dv_tag.neg[k]) begin
        if (dv_ovf[k] || q_rnd[k] > MAX_NEG) begin
          res[k] = MAX_NEG[ELEM_W-1:0];
        end else begin
          res[k] = -$signed(q_rnd[k][ELEM_W-1:0]);
        end
      end else begin
        if (dv_ovf[k] || q_rnd[k] > MAX_POS) begin
          res[k] = MAX_POS[ELEM_W-1:0];
        end else begin
          res[k] = $signed(q_rnd[k][ELEM_W-1:0]);
        end
      end
    end
    out_nxt.n00 = res[0]; out_nxt.n01 = res[1]; out_nxt.n02 = res[2];
    out_nxt.n10 = res[3]; out_nxt.n11 = res[4]; out_nxt.n12 = res[5];
    out_nxt.n20 = res[6]; out_nxt.n21 = res[7]; out_nxt.n22 = res[8];
    out_nxt.singular = dv_tag.singular;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> tb/normal_matrix_checker.sv
// Checker for the normal-matrix unit: predicts each result and compares it with the block.
`timescale 1ns / 1ps
module normal_matrix_checker
  import nmit_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  nmit_in_t         in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  nmit_out_t        out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending_count
);

  localparam int FB = FRAC_BITS_DEF;

  logic [THR_W-1:0] singular_limit;
  nmit_out_t        expected_matrices[$];

  // Rounded, saturated quotient cof * 2^(2*FB) / det on magnitudes.
  function automatic logic [ELEM_W-1:0] scaled_quotient(logic signed [127:0] cof,
                                                        logic signed [127:0] det);
    logic         neg;
    logic [127:0] num;
    logic [127:0] dmag;
    logic [127:0] q;
    neg  = (cof < 0) != (det < 0);
    num  = ((cof < 0) ? -cof : cof) << (2 * FB + 1);
    dmag = (det < 0) ? -det : det;
    q    = (num / dmag + 128'd1) >> 1;
    if (neg) begin
      if (q > 128'h8000_0000) return 32'h8000_0000;
      return -q[ELEM_W-1:0];
    end
    if (q > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return q[ELEM_W-1:0];
  endfunction

  function automatic nmit_out_t normal_of(nmit_in_t m, logic [THR_W-1:0] thr);
    logic signed [127:0] e[9];
    logic signed [127:0] c[9];
    logic signed [127:0] det;
    logic [127:0]        dmag;
    logic [ELEM_W-1:0]   n[9];
    nmit_out_t           r;
    e[0] = m.a00; e[1] = m.a01; e[2] = m.a02;
    e[3] = m.a10; e[4] = m.a11; e[5] = m.a12;
    e[6] = m.a20; e[7] = m.a21; e[8] = m.a22;
    c[0] = e[4] * e[8] - e[5] * e[7];
    c[1] = e[5] * e[6] - e[3] * e[8];
    c[2] = e[3] * e[7] - e[4] * e[6];
    c[3] = e[2] * e[7] - e[1] * e[8];
    c[4] = e[0] * e[8] - e[2] * e[6];
    c[5] = e[1] * e[6] - e[0] * e[7];
    c[6] = e[1] * e[5] - e[2] * e[4];
    c[7] = e[2] * e[3] - e[0] * e[5];
    c[8] = e[0] * e[4] - e[1] * e[3];
    det  = e[0] * c[0] + e[1] * c[1] + e[2] * c[2];
    dmag = (det < 0) ? -det : det;
    if (dmag <= ({97'd0, thr} << (2 * FB))) begin
      for (int i = 0; i < 9; i++) n[i] = (i % 4 == 0) ? (32'd1 << FB) : 32'd0;
      r.singular = 1'b1;
    end else begin
      for (int i = 0; i < 9; i++) n[i] = scaled_quotient(c[i], det);
      r.singular = 1'b0;
    end
    {r.n00, r.n01, r.n02, r.n10, r.n11, r.n12, r.n20, r.n21, r.n22} =
      {n[0], n[1], n[2], n[3], n[4], n[5], n[6], n[7], n[8]};
    return r;
  endfunction

  assign pending_count = expected_matrices.size();

  always @(posedge clk) begin
    nmit_out_t          want;
    logic [ELEM_W-1:0]  wf[9];
    logic [ELEM_W-1:0]  gf[9];
    if (!rst_n) begin
      singular_limit = 31'd1;
      fail_count     = 0;
      expected_matrices.delete();
    end else begin
      if (cfg_valid && cfg_ready) singular_limit = cfg_data;
      if (in_valid && !in_stall) expected_matrices.push_back(normal_of(in_data, singular_limit));
      if (out_valid && !out_stall) begin
        if (expected_matrices.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result item %p", out_data);
        end else begin
          want = expected_matrices.pop_front();
          wf = '{want.n00, want.n01, want.n02, want.n10, want.n11, want.n12,
                 want.n20, want.n21, want.n22};
          gf = '{out_data.n00, out_data.n01, out_data.n02, out_data.n10, out_data.n11,
                 out_data.n12, out_data.n20, out_data.n21, out_data.n22};
          for (int i = 0; i < 9; i++) begin
            if (wf[i] !== gf[i]) begin
              fail_count++;
              if (fail_count <= 10)
                $display("n%0d%0d: expected %h, got %h", i / 3, i % 3, wf[i], gf[i]);
            end
          end
          if (want.singular !== out_data.singular) begin
            fail_count++;
            if (fail_count <= 10)
              $display("singular: expected %b, got %b", want.singular, out_data.singular);
          end
        end
      end
    end
  end

endmodule

>>> tb/normal_matrix_inverse_transpose_tb.sv
// Stimulus and verdict for the normal-matrix unit testbench.
`timescale 1ns / 1ps
module normal_matrix_inverse_transpose_tb;
  import nmit_pkg::*;

  // One in Q16.16.
  localparam logic [31:0] ONE        = 32'h0001_0000;
  localparam int          DRAIN_WAIT = 50;
  localparam int          STUCK_MAX  = 3000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  nmit_in_t         in_data;
  logic             out_valid;
  logic             out_stall;
  nmit_out_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [THR_W-1:0] cfg_data;
  int               fail_count;
  int               pending_count;
  logic             calm;
  int               stuck_cycles;

  normal_matrix_inverse_transpose dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  normal_matrix_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver stalls in random bursts, except once the run has gone calm
  // towards its end.
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        if (hold == 0) out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 6);
        out_stall <= 1'b1;
      end
    end
  end

  // The watchdog ends the run when nothing has been accepted on any channel
  // for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_MAX) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offers one matrix and returns just after the edge at which it is taken.
  // in_stall only moves at rising edges, so it is looked at on the falling one.
  task automatic send_matrix(nmit_in_t m);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // Waits until every expected item has come back and the pipeline is empty,
  // then writes the threshold.
  task automatic set_threshold(logic [THR_W-1:0] thr);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic nmit_in_t diag_matrix(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    nmit_in_t m;
    m     = '0;
    m.a00 = x;
    m.a11 = y;
    m.a22 = z;
    return m;
  endfunction

  // Element of moderate size around one, so that most inverses stay in range.
  function automatic logic [31:0] modest_element();
    logic [31:0] v;
    v = $urandom_range(0, 32'h0003_FFFF);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic nmit_in_t random_matrix();
    nmit_in_t m;
    int       kind;
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      // Well-conditioned: mostly modest elements, a dominant diagonal at times.
      m = {modest_element(), modest_element(), modest_element(),
           modest_element(), modest_element(), modest_element(),
           modest_element(), modest_element(), modest_element()};
      if (kind == 0) begin
        m.a00 = m.a00 + (ONE << 1);
        m.a11 = m.a11 - (ONE << 1);
        m.a22 = m.a22 + (ONE << 1);
      end
    end else if (kind < 7) begin
      // Full-range bit patterns.
      m = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom()};
    end else if (kind == 7) begin
      // Two equal rows: exactly singular whatever the content.
      m = {modest_element(), modest_element(), modest_element(),
           $urandom(), $urandom(), $urandom(), 96'd0};
      {m.a20, m.a21, m.a22} = {m.a10, m.a11, m.a12};
    end else if (kind == 8) begin
      // Tiny elements: determinant near the threshold.
      m = {32'($urandom_range(0, 300)), 32'($urandom_range(0, 300)),
           32'($urandom_range(0, 300)), 32'($urandom_range(0, 300)),
           32'($urandom_range(0, 300)), 32'($urandom_range(0, 300)),
           32'($urandom_range(0, 300)), 32'($urandom_range(0, 300)),
           32'($urandom_range(0, 300))};
      m.a11 = -m.a11;
    end else begin
      // Sparse: a permuted, scaled diagonal with signs.
      m = '0;
      m.a01 = modest_element() << $urandom_range(0, 12);
      m.a12 = modest_element();
      m.a20 = modest_element() >>> $urandom_range(0, 12);
    end
    return m;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_matrix(random_matrix());
  endtask

  initial begin
    calm      = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset threshold.
    send_matrix(diag_matrix(ONE, ONE, ONE));
    send_matrix('0);
    send_matrix({9{32'h7FFF_FFFF}});
    send_matrix({9{32'h8000_0000}});
    send_matrix(diag_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_matrix(diag_matrix(ONE << 1, ONE << 2, -(ONE << 3)));
    send_matrix(diag_matrix(3 * ONE, 3 * ONE, 3 * ONE));
    // Determinant exactly at the threshold, and one step above it.
    send_matrix(diag_matrix(ONE, ONE, 32'd1));
    send_matrix(diag_matrix(ONE, ONE, 32'd2));
    send_matrix(diag_matrix(ONE, ONE, -32'd2));
    // Large quotients of both signs that still fit in range.
    send_matrix(diag_matrix(ONE, ONE >> 8, ONE >> 7));
    send_matrix(diag_matrix(ONE, -(ONE >> 8), ONE >> 7));
    // A rotation-like matrix with off-diagonal terms and a negative determinant.
    send_matrix({32'h0000_B505, 32'hFFFF_4AFB, 32'd0,
                 32'h0000_B505, 32'h0000_B505, 32'd0,
                 32'd0, 32'd0, -ONE});
    send_matrix({ONE, ONE << 1, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                 7 * ONE, 8 * ONE, 10 * ONE});
    send_matrix({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom()});
    random_phase(120);

    // A zero threshold: only an exactly zero determinant is singular.
    set_threshold('0);
    send_matrix(diag_matrix(32'd1, 32'd1, 32'd1));
    send_matrix(diag_matrix(ONE, ONE, 32'd0));
    random_phase(150);

    // The largest threshold: almost everything is singular.
    set_threshold(31'h7FFF_FFFF);
    send_matrix({9{32'h7FFF_FFFF}});
    send_matrix(diag_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    random_phase(60);

    // One in fixed point, then a random one.
    set_threshold(31'h0001_0000);
    send_matrix(diag_matrix(ONE, ONE, ONE));
    send_matrix(diag_matrix(ONE, ONE, ONE + 1));
    random_phase(150);

    set_threshold(31'($urandom()));
    random_phase(100);

    // Back to a small threshold; the last stretch runs without any idling.
    set_threshold(31'($urandom_range(1, 1000)));
    random_phase(60);
    calm = 1'b1;
    random_phase(60);

    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
